>>> rtl/bpe_pkg.sv
`default_nettype none
package bpe_pkg;

	localparam int MAX_DEGREE = 4;
	localparam int FRAC_BITS = 16;
	localparam int NUM_COEFS = 5;
	localparam int DIV_STAGES = FRAC_BITS;
	localparam int MAP_STAGES = DIV_STAGES + 2;
	localparam int HORNER_STAGES = 2 * MAX_DEGREE;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_CHECK,
		REG_LOWER,
		REG_UPPER,
		REG_COEF0,
		REG_COEF1,
		REG_COEF2,
		REG_COEF3,
		REG_COEF4
	} reg_idx_t;

	typedef struct packed {
		logic check;
		logic signed [31:0] lower;
		logic signed [31:0] upper;
		logic [NUM_COEFS-1:0][31:0] coef;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] u;
		logic signed [31:0] acc;
		logic signed [63:0] prod;
		logic [31:0] rem;
		logic [FRAC_BITS-1:0] quo;
		logic neg;
		logic bypass;
		logic oor;
		logic ovf;
	} pipe_t;

endpackage
`default_nettype wire

>>> rtl/bounded_polynomial_evaluator.sv
// bounded polynomial evaluator, degree four, signed Q16.16
//
// input channel: in_valid / in_ready carry one sample x_value per transfer.
// output channel: out_valid / out_ready carry result_value, out_of_range
// and overflow, one result per sample, in order.
// configuration: APB-style port, register i at byte address 4*i, pready
// always high; write only while no sample is in flight.
//
// from input transfer to output transfer a sample passes one stage for the
// range check, 16 stages of the restoring divider (one quotient bit each),
// one stage to sign the mapped sample, then a multiply stage and an
// add/saturate stage for each of the four Horner steps.
// throughput is one sample per cycle while out_ready stays high; the 32x32
// multiply and the one-bit-per-stage divider set the stage depth.
//
// reset empties the pipeline and loads the register reset values.
// when the receiver stalls, each stage holds only while the stage after it
// is full, so bubbles close up and input keeps flowing until every stage
// holds a sample.
`default_nettype none
module bounded_polynomial_evaluator import bpe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [31:0] x_value,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [31:0] result_value,
	output logic out_of_range,
	output logic overflow
);

	cfg_t cfg_q;
	reg_idx_t idx;
	pipe_t in_p;
	pipe_t mid_p;
	pipe_t out_p;
	logic mid_valid;
	logic mid_ready;

	assign idx = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check <= 1'b0;
			cfg_q.lower <= -32'sd65536;
			cfg_q.upper <= 32'sd65536;
			cfg_q.coef <= {128'd0, 32'd65536};
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_CHECK: cfg_q.check <= pwdata[0];
				REG_LOWER: cfg_q.lower <= pwdata;
				REG_UPPER: cfg_q.upper <= pwdata;
				REG_COEF0: cfg_q.coef[0] <= pwdata;
				REG_COEF1: cfg_q.coef[1] <= pwdata;
				REG_COEF2: cfg_q.coef[2] <= pwdata;
				REG_COEF3: cfg_q.coef[3] <= pwdata;
				REG_COEF4: cfg_q.coef[4] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CHECK: prdata = {31'd0, cfg_q.check};
			REG_LOWER: prdata = cfg_q.lower;
			REG_UPPER: prdata = cfg_q.upper;
			REG_COEF0: prdata = cfg_q.coef[0];
			REG_COEF1: prdata = cfg_q.coef[1];
			REG_COEF2: prdata = cfg_q.coef[2];
			REG_COEF3: prdata = cfg_q.coef[3];
			REG_COEF4: prdata = cfg_q.coef[4];
			default: prdata = '0;
		endcase
	end

	always_comb begin
		in_p = '0;
		in_p.u = x_value;
	end

	bpe_map u_map (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_p),
		.out_valid(mid_valid),
		.out_ready(mid_ready),
		.out_data(mid_p)
	);

	bpe_horner u_horner (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(mid_valid),
		.in_ready(mid_ready),
		.in_data(mid_p),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_p)
	);

	assign result_value = out_p.acc;
	assign out_of_range = out_p.oor;
	assign overflow = out_p.ovf;

endmodule
`default_nettype wire

>>> rtl/bpe_map.sv
`default_nettype none
module bpe_map import bpe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire pipe_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output pipe_t out_data
);

	localparam int N = MAP_STAGES;

	logic v_s [N];
	pipe_t d_s [N];
	pipe_t nxt [N];
	logic rdy [N];

	always_comb begin
		rdy[N-1] = !v_s[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		logic signed [32:0] diff;
		logic [32:0] den33;
		logic signed [33:0] num;
		logic [33:0] absnum;
		logic [32:0] rem2;
		logic in_rng;
		diff = {cfg.upper[31], cfg.upper} - {cfg.lower[31], cfg.lower};
		den33 = {1'b0, diff[31:0]};

		// range check and numerator of the unit mapping
		in_rng = (in_data.u > cfg.lower) && (in_data.u < cfg.upper);
		num = {in_data.u[31], in_data.u, 1'b0}
			- ({{2{cfg.upper[31]}}, cfg.upper} + {{2{cfg.lower[31]}}, cfg.lower});
		absnum = num[33] ? 34'(-num) : 34'(num);
		nxt[0] = in_data;
		nxt[0].rem = absnum[31:0];
		nxt[0].quo = '0;
		nxt[0].neg = num[33];
		nxt[0].bypass = !cfg.check;
		nxt[0].oor = cfg.check && !in_rng;
		nxt[0].ovf = 1'b0;

		// restoring division, one quotient bit per stage
		for (int k = 1; k <= DIV_STAGES; k++) begin
			nxt[k] = d_s[k-1];
			rem2 = {d_s[k-1].rem, 1'b0};
			if (rem2 >= den33) begin
				nxt[k].rem = 32'(rem2 - den33);
				nxt[k].quo = {d_s[k-1].quo[FRAC_BITS-2:0], 1'b1};
			end else begin
				nxt[k].rem = rem2[31:0];
				nxt[k].quo = {d_s[k-1].quo[FRAC_BITS-2:0], 1'b0};
			end
		end

		nxt[N-1] = d_s[N-2];
		if (!d_s[N-2].bypass) begin
			nxt[N-1].u = d_s[N-2].neg ? -$signed({{(32-FRAC_BITS){1'b0}}, d_s[N-2].quo})
				: $signed({{(32-FRAC_BITS){1'b0}}, d_s[N-2].quo});
		end
		nxt[N-1].acc = $signed(cfg.coef[MAX_DEGREE]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) v_s[k] <= 1'b0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (rdy[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (rdy[k]) d_s[k] <= nxt[k];
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = v_s[N-1];
	assign out_data = d_s[N-1];

endmodule
`default_nettype wire

>>> rtl/bpe_horner.sv
`default_nettype none
module bpe_horner import bpe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire pipe_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output pipe_t out_data
);

	localparam int N = HORNER_STAGES;
	localparam int SW = 64 - FRAC_BITS;

	logic v_s [N];
	pipe_t d_s [N];
	pipe_t nxt [N];
	logic rdy [N];

	always_comb begin
		rdy[N-1] = !v_s[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		pipe_t src;
		logic signed [SW:0] sum;
		for (int j = 0; j < MAX_DEGREE; j++) begin
			// multiply stage
			src = (j == 0) ? in_data : d_s[(2*j + N - 1) % N];
			nxt[2*j] = src;
			nxt[2*j].prod = src.acc * src.u;

			// floor shift, add coefficient, saturate; on the last step an out-of-range sample gives S32_MAX
			nxt[2*j+1] = d_s[2*j];
			sum = $signed(d_s[2*j].prod[63:FRAC_BITS])
				+ $signed({{(SW-31){cfg.coef[MAX_DEGREE-1-j][31]}}, cfg.coef[MAX_DEGREE-1-j]});
			if ((&sum[SW:31]) || !(|sum[SW:31])) begin
				nxt[2*j+1].acc = sum[31:0];
			end else begin
				nxt[2*j+1].acc = sum[SW] ? S32_MIN : S32_MAX;
				nxt[2*j+1].ovf = 1'b1;
			end
			if (j == MAX_DEGREE - 1 && d_s[2*j].oor) begin
				nxt[2*j+1].acc = S32_MAX;
				nxt[2*j+1].ovf = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) v_s[k] <= 1'b0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (rdy[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (rdy[k]) d_s[k] <= nxt[k];
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = v_s[N-1];
	assign out_data = d_s[N-1];

endmodule
`default_nettype wire
